// File: rtl/gated_position_mahalanobis_cost_defines.svh
// Assertion macros used by the checker file.
`ifndef GATED_POSITION_MAHALANOBIS_COST_DEFINES_SVH
`define GATED_POSITION_MAHALANOBIS_COST_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define GPMC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gpmc assertion failed");

// Next-cycle implication.
`define GPMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gpmc assertion failed");

`endif

// File: rtl/gpmc_pkg.sv
package gpmc_pkg;

  localparam int MAX_TRACKS = 64;
  localparam int SLOT_W     = $clog2(MAX_TRACKS);
  localparam int COUNT_W    = 7;
  localparam int POS_W      = 32;
  localparam int INV_W      = 48;
  localparam int COST_W     = 48;

  localparam logic [0:0] REG_MAX_RADIUS  = 1'b0;
  localparam logic [0:0] REG_TRACK_COUNT = 1'b1;

  localparam logic [0:0] CMD_LOAD    = 1'b0;
  localparam logic [0:0] CMD_MEASURE = 1'b1;

  localparam logic [COST_W-1:0] BOUND_COST = 48'd65536000;
  localparam logic [COST_W-1:0] COST_MAX   = 48'h7FFF_FFFF_FFFF;
  localparam logic [COST_W-1:0] COST_MIN   = 48'h8000_0000_0000;

  typedef struct packed {
    logic              valid;
    logic [POS_W-1:0]  pred_x;
    logic [POS_W-1:0]  pred_y;
    logic [INV_W-1:0]  inv_xx;
    logic [INV_W-1:0]  inv_xy;
    logic [INV_W-1:0]  inv_yy;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic        start;
    logic        neg;
    logic [31:0] num;
    logic [63:0] den;
  } div_req_t;

endpackage

// File: rtl/gpmc_ram.sv
module gpmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/gpmc_div.sv
module gpmc_div
  import gpmc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             done,
  output logic [INV_W-1:0] quo
);

  // Restoring division, one quotient bit per cycle: num * 2^48 / den,
  // rounded toward zero, signed and saturated to 48 bits.
  logic [63:0]      rem_r;
  logic [INV_W-1:0] q_r;
  logic [5:0]       cnt_r;
  logic             run_r, fin_r, done_r, neg_r;
  logic [INV_W-1:0] quo_r;
  logic [64:0]      rem_sh;
  logic             fits;

  assign rem_sh = {rem_r, 1'b0};
  assign fits   = rem_sh >= {1'b0, req.den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      if (req.start) begin
        neg_r <= req.neg;
        if ({32'd0, req.num} >= req.den) begin
          quo_r  <= req.neg ? COST_MIN : COST_MAX;
          done_r <= 1'b1;
        end else begin
          rem_r <= {32'd0, req.num};
          q_r   <= '0;
          cnt_r <= '0;
          run_r <= 1'b1;
        end
      end else if (run_r) begin
        if (fits) begin
          rem_r <= 64'(rem_sh - {1'b0, req.den});
        end else begin
          rem_r <= rem_sh[63:0];
        end
        q_r   <= {q_r[INV_W-2:0], fits};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(INV_W - 1)) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        if (neg_r) begin
          quo_r <= (q_r > COST_MIN) ? COST_MIN : INV_W'(-q_r);
        end else begin
          quo_r <= (q_r >= COST_MIN) ? COST_MAX : q_r;
        end
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: rtl/gated_position_mahalanobis_cost.sv
// Channel  | Ports                                    | Handshake
// input    | in_command, in_slot, in_pos_*, in_cov_*  | start while busy is low
// result   | out_track_index, out_cost, out_gated,    | out_strobe, one cycle
//          | out_last                                 |
// config   | cfg_index, cfg_data                      | cfg_we
//
// A load keeps busy high while the shared multiplier forms the determinant (S_LMUL0,
// S_LMUL1, S_LDET, then S_LCHK tests it), the bit-serial divider forms the three inverse
// entries one after the other unless the determinant is zero, and S_LWR writes the entry.
// A measurement keeps busy high until all n tracks are scored: one shared
// 32x32 multiplier does 15 products per track and each track reads its memory
// entry. The final result shows in the first idle cycle; with n = 0 busy stays low.
// Reset is synchronous; the track memory is not cleared and is valid once loaded.
// Results cannot be stalled; each one is shown on the ports for one cycle.
module gated_position_mahalanobis_cost
  import gpmc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_command,
  input  logic [SLOT_W-1:0]   in_slot,
  input  logic signed [31:0]  in_pos_x,
  input  logic signed [31:0]  in_pos_y,
  input  logic signed [31:0]  in_cov_xx,
  input  logic signed [31:0]  in_cov_xy,
  input  logic signed [31:0]  in_cov_yy,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output logic                out_strobe,
  output logic [SLOT_W-1:0]   out_track_index,
  output logic signed [47:0]  out_cost,
  output logic                out_gated,
  output logic                out_last
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LMUL0 = 4'd1;
  localparam logic [3:0] S_LMUL1 = 4'd2;
  localparam logic [3:0] S_LDET  = 4'd3;
  localparam logic [3:0] S_LCHK  = 4'd4;
  localparam logic [3:0] S_LDIV  = 4'd5;
  localparam logic [3:0] S_LWR   = 4'd6;
  localparam logic [3:0] S_MRR   = 4'd7;
  localparam logic [3:0] S_MRD   = 4'd8;
  localparam logic [3:0] S_MLAT  = 4'd9;
  localparam logic [3:0] S_MSTEP = 4'd10;
  localparam logic [3:0] S_MDRN  = 4'd11;
  localparam logic [3:0] S_MOUT  = 4'd12;

  localparam logic [3:0] LAST_STEP = 4'd14;

  logic [3:0] state_r;

  logic [31:0]        max_radius_r;
  logic [COUNT_W-1:0] track_count_r;

  // Latched command.
  logic [SLOT_W-1:0]  slot_r;
  logic [31:0]        px_r, py_r;
  logic [31:0]        mxx_r, mxy_r, myy_r;
  logic               nxx_r, nyy_r, pxy_r;
  logic [COUNT_W-1:0] n_r;

  // Load path.
  logic [64:0]      det_r;
  logic [63:0]      dm_r;
  logic             dneg_r;
  logic [1:0]       div_idx_r;
  logic             launched_r;
  logic [INV_W-1:0] ixx_r, ixy_r, iyy_r;
  logic             valid_r;
  div_req_t         div_req;
  logic             div_done;
  logic [INV_W-1:0] div_quo;

  // Measurement path.
  logic [SLOT_W-1:0] k_r;
  logic [63:0]       rr_r;
  logic [32:0]       ax_r, ay_r;
  logic              sgn_r;
  logic              ent_valid_r;
  logic [INV_W-1:0]  cxx_r, cxy_r, cyy_r;
  logic              cnxx_r, cnxy_r, cnyy_r;
  logic [63:0]       sxx_r, syy_r, sxy_r;
  logic              gate_r;
  logic [3:0]        step_r, tag_r;
  logic              tag_v_r;
  logic [127:0]      acc_r;
  logic [63:0]       prod_r;

  logic [31:0] mul_a, mul_b;
  entry_t      wr_ent, rd_ent;
  logic [ENTRY_W-1:0] rd_raw;

  logic out_strobe_r, out_gated_r, out_last_r;
  logic [SLOT_W-1:0] out_idx_r;
  logic [COST_W-1:0] out_cost_r;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? 32'(-v) : v;
  endfunction

  function automatic logic [INV_W-1:0] mag48(input logic [INV_W-1:0] v);
    mag48 = v[INV_W-1] ? INV_W'(-v) : v;
  endfunction

  // Partial-product select for steps after the two squares and the cross product.
  logic [3:0]       j_s, j_t;
  logic [INV_W-1:0] cm_s;
  logic [63:0]      p_s;
  logic [6:0]       shamt;
  logic             pneg;
  logic [127:0]     addend;
  logic [64:0]      sq_sum;
  logic [32:0]      dx, dy;
  logic [COST_W-1:0] cost_sat;

  assign j_s = step_r - 4'd3;
  assign j_t = tag_r - 4'd3;

  always_comb begin
    case (j_s[3:2])
      2'd0:    begin cm_s = cxx_r; p_s = sxx_r; end
      2'd1:    begin cm_s = cyy_r; p_s = syy_r; end
      default: begin cm_s = cxy_r; p_s = sxy_r; end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_LMUL0: begin mul_a = mxx_r; mul_b = myy_r; end
      S_LMUL1: begin mul_a = mxy_r; mul_b = mxy_r; end
      S_MRR:   begin mul_a = max_radius_r; mul_b = max_radius_r; end
      S_MSTEP: begin
        case (step_r)
          4'd0: begin mul_a = ax_r[31:0]; mul_b = ax_r[31:0]; end
          4'd1: begin mul_a = ay_r[31:0]; mul_b = ay_r[31:0]; end
          4'd2: begin mul_a = ax_r[31:0]; mul_b = ay_r[31:0]; end
          default: begin
            mul_a = j_s[1] ? {16'd0, cm_s[47:32]} : cm_s[31:0];
            mul_b = j_s[0] ? p_s[63:32] : p_s[31:0];
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Shift and sign of the product that comes back from the multiplier.
  always_comb begin
    shamt = 7'd32 * (7'(j_t[1]) + 7'(j_t[0])) + 7'(j_t[3:2] == 2'd2);
    case (j_t[3:2])
      2'd0:    pneg = cnxx_r;
      2'd1:    pneg = cnyy_r;
      default: pneg = cnxy_r ^ sgn_r;
    endcase
    addend = ({64'd0, prod_r} << shamt) ^ {128{pneg}};
  end

  assign sq_sum = {1'b0, sxx_r} + {1'b0, syy_r};
  assign dx = {px_r[31], px_r} - {rd_ent.pred_x[31], rd_ent.pred_x};
  assign dy = {py_r[31], py_r} - {rd_ent.pred_y[31], rd_ent.pred_y};

  always_comb begin
    if (!acc_r[127] && acc_r[127:64] >= 64'h0000_0000_8000_0000) begin
      cost_sat = COST_MAX;
    end else if (acc_r[127] && acc_r[127:64] < 64'hFFFF_FFFF_8000_0000) begin
      cost_sat = COST_MIN;
    end else begin
      cost_sat = acc_r[95:48];
    end
  end

  always_comb begin
    div_req.start = (state_r == S_LDIV) && !launched_r;
    div_req.den   = dm_r;
    case (div_idx_r)
      2'd0:    begin div_req.num = myy_r; div_req.neg = nyy_r ^ dneg_r; end
      2'd1:    begin div_req.num = mxy_r; div_req.neg = pxy_r ^ dneg_r; end
      default: begin div_req.num = mxx_r; div_req.neg = nxx_r ^ dneg_r; end
    endcase
  end

  gpmc_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  assign wr_ent = '{valid: valid_r, pred_x: px_r, pred_y: py_r,
                    inv_xx: ixx_r, inv_xy: ixy_r, inv_yy: iyy_r};
  assign rd_ent = entry_t'(rd_raw);

  gpmc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_TRACKS)) u_ram (
    .clk  (clk),
    .we   (state_r == S_LWR),
    .waddr(slot_r),
    .wdata(wr_ent),
    .raddr(k_r),
    .rdata(rd_raw)
  );

  always_ff @(posedge clk) begin
    prod_r  <= mul_a * mul_b;
    tag_v_r <= (state_r == S_MSTEP);
    tag_r   <= step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      max_radius_r  <= 32'd327680;
      track_count_r <= '0;
      out_strobe_r  <= 1'b0;
      launched_r    <= 1'b0;
      div_idx_r     <= '0;
      k_r           <= '0;
      step_r        <= '0;
    end else begin
      out_strobe_r <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_RADIUS:  max_radius_r  <= cfg_data;
          REG_TRACK_COUNT: track_count_r <= cfg_data[COUNT_W-1:0];
          default:         max_radius_r  <= max_radius_r;
        endcase
      end

      // Results of the shared multiplier during a track's step sequence.
      if (tag_v_r) begin
        case (tag_r)
          4'd0: sxx_r <= prod_r;
          4'd1: syy_r <= prod_r;
          4'd2: begin
            sxy_r  <= prod_r;
            gate_r <= ax_r[32] || ay_r[32] || sq_sum[64] || (sq_sum[63:0] > rr_r)
                      || !ent_valid_r;
          end
          default: acc_r <= acc_r + addend + 128'(pneg);
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (start) begin
            slot_r <= in_slot;
            px_r   <= in_pos_x;
            py_r   <= in_pos_y;
            mxx_r  <= mag32(in_cov_xx);
            mxy_r  <= mag32(in_cov_xy);
            myy_r  <= mag32(in_cov_yy);
            nxx_r  <= in_cov_xx[31];
            nyy_r  <= in_cov_yy[31];
            pxy_r  <= !in_cov_xy[31] && (in_cov_xy != 32'sd0);
            n_r    <= (track_count_r > COUNT_W'(MAX_TRACKS)) ?
                      COUNT_W'(MAX_TRACKS) : track_count_r;
            if (in_command == CMD_LOAD) begin
              state_r <= S_LMUL0;
            end else if (track_count_r != '0) begin
              state_r <= S_MRR;
            end
          end
        end
        S_LMUL0: state_r <= S_LMUL1;
        S_LMUL1: begin
          det_r   <= (nxx_r ^ nyy_r) ? 65'(-{1'b0, prod_r}) : {1'b0, prod_r};
          state_r <= S_LDET;
        end
        S_LDET: begin
          det_r   <= det_r - {1'b0, prod_r};
          state_r <= S_LCHK;
        end
        S_LCHK: begin
          if (det_r == '0) begin
            ixx_r   <= '0;
            ixy_r   <= '0;
            iyy_r   <= '0;
            valid_r <= 1'b0;
            state_r <= S_LWR;
          end else begin
            valid_r   <= 1'b1;
            dneg_r    <= det_r[64];
            dm_r      <= det_r[64] ? 64'(-det_r) : det_r[63:0];
            div_idx_r <= '0;
            state_r   <= S_LDIV;
          end
        end
        S_LDIV: begin
          if (!launched_r) begin
            launched_r <= 1'b1;
          end else if (div_done) begin
            launched_r <= 1'b0;
            div_idx_r  <= div_idx_r + 2'd1;
            case (div_idx_r)
              2'd0:    ixx_r <= div_quo;
              2'd1:    ixy_r <= div_quo;
              default: iyy_r <= div_quo;
            endcase
            if (div_idx_r == 2'd2) begin
              state_r <= S_LWR;
            end
          end
        end
        S_LWR: state_r <= S_IDLE;
        S_MRR: begin
          k_r     <= '0;
          state_r <= S_MRD;
        end
        S_MRD: begin
          if (k_r == '0) begin
            rr_r <= prod_r;
          end
          state_r <= S_MLAT;
        end
        S_MLAT: begin
          ax_r        <= dx[32] ? 33'(-dx) : dx;
          ay_r        <= dy[32] ? 33'(-dy) : dy;
          sgn_r       <= dx[32] ^ dy[32];
          ent_valid_r <= rd_ent.valid;
          cxx_r       <= mag48(rd_ent.inv_xx);
          cxy_r       <= mag48(rd_ent.inv_xy);
          cyy_r       <= mag48(rd_ent.inv_yy);
          cnxx_r      <= rd_ent.inv_xx[INV_W-1];
          cnxy_r      <= rd_ent.inv_xy[INV_W-1];
          cnyy_r      <= rd_ent.inv_yy[INV_W-1];
          acc_r       <= '0;
          step_r      <= '0;
          state_r     <= S_MSTEP;
        end
        S_MSTEP: begin
          step_r <= step_r + 4'd1;
          if (step_r == LAST_STEP) begin
            state_r <= S_MDRN;
          end
        end
        S_MDRN: state_r <= S_MOUT;
        S_MOUT: begin
          out_strobe_r <= 1'b1;
          out_idx_r    <= k_r;
          out_gated_r  <= gate_r;
          out_cost_r   <= gate_r ? BOUND_COST : cost_sat;
          out_last_r   <= ({1'b0, k_r} + COUNT_W'(1)) == n_r;
          if (({1'b0, k_r} + COUNT_W'(1)) == n_r) begin
            state_r <= S_IDLE;
          end else begin
            k_r     <= k_r + SLOT_W'(1);
            state_r <= S_MRD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_strobe      = out_strobe_r;
  assign out_track_index = out_idx_r;
  assign out_cost        = out_cost_r;
  assign out_gated       = out_gated_r;
  assign out_last        = out_last_r;

endmodule

// File: rtl/gpmc_chk.sv
`include "gated_position_mahalanobis_cost_defines.svh"

module gpmc_chk
  import gpmc_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                in_command,
  input logic                out_strobe,
  input logic signed [47:0]  out_cost,
  input logic                out_gated,
  input logic                out_last
);

  // A gated result always carries the bound cost.
  `GPMC_ASSERT_NOW(a_gated_bound, out_strobe && out_gated, out_cost == BOUND_COST)
  // An accepted load keeps the block busy in the next cycle.
  `GPMC_ASSERT_NEXT(a_start_busy, start && !busy && in_command == CMD_LOAD, busy)
  // No two results are strobed in back-to-back cycles.
  `GPMC_ASSERT_NEXT(a_no_double, out_strobe, !out_strobe)
  // The final result of a row leaves the block idle; earlier ones do not.
  `GPMC_ASSERT_NOW(a_last_idle, out_strobe, out_last == !busy)

endmodule

bind gated_position_mahalanobis_cost gpmc_chk u_gpmc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_command(in_command),
  .out_strobe(out_strobe),
  .out_cost  (out_cost),
  .out_gated (out_gated),
  .out_last  (out_last)
);

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import gpmc_pkg::*;

  typedef struct {
    logic [SLOT_W-1:0]  track_index;
    logic [COST_W-1:0]  cost;
    logic               gated;
    logic               last;
  } cost_rec_t;

  // Scoreboard: mirrors the track table and the registers, and predicts one
  // row of costs for every measurement transfer.
  class cost_board;
    longint          pred_x [MAX_TRACKS];
    longint          pred_y [MAX_TRACKS];
    longint          inv_xx [MAX_TRACKS];
    longint          inv_xy [MAX_TRACKS];
    longint          inv_yy [MAX_TRACKS];
    bit              trk_ok [MAX_TRACKS];
    bit [31:0]       radius;
    bit [6:0]        count;
    cost_rec_t       row_q [$];
    int              errors;

    function new();
      radius = 32'd327680;
      count  = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [31:0] data);
      if (idx == REG_MAX_RADIUS) radius = data;
      else count = data[COUNT_W-1:0];
    endfunction

    function int outstanding();
      return row_q.size();
    endfunction

    // Signed num * 2^48 / den, toward zero, clipped to 48 bits signed.
    function longint inv_div(longint unsigned nm, bit nneg, longint unsigned dm);
      logic [127:0] q;
      longint       lim;
      lim = 64'sh8000_0000_0000;
      if (nm >= dm) return nneg ? -lim : lim - 1;
      q = ({64'd0, nm} << 48) / {64'd0, dm};
      if (nneg) return (q > 128'(lim)) ? -lim : -longint'(q[63:0]);
      return (q >= 128'(lim)) ? lim - 1 : longint'(q[63:0]);
    endfunction

    function void note_item(logic cmd, logic [SLOT_W-1:0] s,
                            logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [31:0] cxx, logic signed [31:0] cxy,
                            logic signed [31:0] cyy);
      longint           det;
      longint unsigned  dm;
      int               n;
      cost_rec_t        r;
      bit               g;
      if (cmd == CMD_LOAD) begin
        det = longint'(cxx) * longint'(cyy) - longint'(cxy) * longint'(cxy);
        pred_x[s] = px;
        pred_y[s] = py;
        if (det == 0) begin
          inv_xx[s] = 0; inv_xy[s] = 0; inv_yy[s] = 0;
          trk_ok[s] = 0;
        end else begin
          dm = (det < 0) ? -det : det;
          inv_xx[s] = inv_div((cyy < 0) ? -longint'(cyy) : cyy, (cyy < 0) != (det < 0), dm);
          inv_xy[s] = inv_div((cxy < 0) ? -longint'(cxy) : cxy, (cxy > 0) != (det < 0), dm);
          inv_yy[s] = inv_div((cxx < 0) ? -longint'(cxx) : cxx, (cxx < 0) != (det < 0), dm);
          trk_ok[s] = 1;
        end
      end else begin
        n = (count > MAX_TRACKS) ? MAX_TRACKS : count;
        for (int k = 0; k < n; k++) begin
          r.track_index = SLOT_W'(k);
          r.cost  = cost_of(k, px, py, g);
          r.gated = g;
          r.last  = (k == n - 1);
          row_q.push_back(r);
        end
      end
    endfunction

    function logic [COST_W-1:0] cost_of(int k, longint mx, longint my, output bit g);
      longint             dx, dy;
      longint unsigned    ax, ay, rr;
      logic [64:0]        dist2;
      logic signed [127:0] wdx, wdy, wxx, wxy, wyy, acc, q, hi, lo;
      dx = mx - pred_x[k];
      dy = my - pred_y[k];
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      rr = longint'(radius) * longint'(radius);
      dist2 = {1'b0, ax * ax} + {1'b0, ay * ay};
      g = 1;
      // Radius test first, then validity; either gives the bound.
      if (dist2 > {1'b0, rr} || !trk_ok[k]) return BOUND_COST;
      g = 0;
      wdx = dx; wdy = dy;
      wxx = inv_xx[k]; wxy = inv_xy[k]; wyy = inv_yy[k];
      acc = wxx * wdx * wdx + 2 * wxy * wdx * wdy + wyy * wdy * wdy;
      q  = acc >>> 48;
      hi = 128'sh7FFF_FFFF_FFFF;
      lo = -128'sh8000_0000_0000;
      if (q > hi) return COST_MAX;
      if (q < lo) return COST_MIN;
      return q[COST_W-1:0];
    endfunction

    function void check_cost(logic [SLOT_W-1:0] idx, logic [COST_W-1:0] c,
                             logic g, logic l);
      cost_rec_t e;
      if (row_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected cost: slot %0d cost %h gated %b last %b", idx, c, g, l);
        return;
      end
      e = row_q.pop_front();
      if (idx !== e.track_index || c !== e.cost || g !== e.gated || l !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("cost mismatch: exp slot %0d cost %h gated %b last %b, got slot %0d cost %h gated %b last %b",
                   e.track_index, e.cost, e.gated, e.last, idx, c, g, l);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_command;
  logic [SLOT_W-1:0]   in_slot;
  logic signed [31:0]  in_pos_x, in_pos_y, in_cov_xx, in_cov_xy, in_cov_yy;
  logic                cfg_we;
  logic [0:0]          cfg_index;
  logic [31:0]         cfg_data;
  logic                out_strobe;
  logic [SLOT_W-1:0]   out_track_index;
  logic signed [47:0]  out_cost;
  logic                out_gated;
  logic                out_last;

  cost_board sb = new();
  bit        loaded [MAX_TRACKS];
  int        rand_items;
  bit        gaps_on;

  gated_position_mahalanobis_cost dut (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  initial begin
    #50_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk)
    if (rst_n && out_strobe) sb.check_cost(out_track_index, out_cost, out_gated, out_last);

  // Start stays high after a transfer; whoever does not send next lowers it.
  task automatic send(logic cmd, logic [SLOT_W-1:0] s, logic signed [31:0] px,
                      logic signed [31:0] py, logic signed [31:0] cxx,
                      logic signed [31:0] cxy, logic signed [31:0] cyy);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd; in_slot <= s;
    in_pos_x <= px; in_pos_y <= py;
    in_cov_xx <= cxx; in_cov_xy <= cxy; in_cov_yy <= cyy;
    do @(posedge clk); while (busy);
    sb.note_item(cmd, s, px, py, cxx, cxy, cyy);
    if (cmd == CMD_LOAD) loaded[s] = 1;
    rand_items++;
  endtask

  // A load leaves no result behind, so wait out its latency too.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (busy || sb.outstanding() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] r, logic [6:0] n);
    drain();
    cfg_we <= 1'b1; cfg_index <= REG_MAX_RADIUS; cfg_data <= r;
    @(posedge clk);
    sb.set_reg(REG_MAX_RADIUS, r);
    cfg_index <= REG_TRACK_COUNT; cfg_data <= {25'd0, n};
    @(posedge clk);
    sb.set_reg(REG_TRACK_COUNT, {25'd0, n});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_sane(logic [SLOT_W-1:0] s, logic signed [31:0] px,
                           logic signed [31:0] py);
    int unsigned a, b, lim;
    int          xy;
    a = $urandom_range(1 << 10, 1 << 20);
    b = $urandom_range(1 << 10, 1 << 20);
    lim = ((a < b) ? a : b) / 2;
    xy = $urandom_range(0, lim);
    if ($urandom_range(0, 1)) xy = -xy;
    send(CMD_LOAD, s, px, py, a, xy, b);
  endtask

  // Measurements may only touch slots that were loaded since reset.
  task automatic fill_slots(int n);
    for (int k = 0; k < n && k < MAX_TRACKS; k++)
      if (!loaded[k]) begin
        load_sane(SLOT_W'(k), $urandom_range(0, 1 << 21) - (1 << 20),
                  $urandom_range(0, 1 << 21) - (1 << 20));
      end
  endtask

  task automatic random_item(int n);
    int          kind, k;
    logic [31:0] v;
    kind = $urandom_range(0, 9);
    if (kind <= 2)
      load_sane(SLOT_W'($urandom_range(0, 63)), $urandom_range(0, 1 << 21) - (1 << 20),
                $urandom_range(0, 1 << 21) - (1 << 20));
    else if (kind == 3)
      send(CMD_LOAD, SLOT_W'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
    else if (kind == 4) begin
      // Singular covariance: all three entries equal.
      v = $urandom_range(0, 1 << 20);
      send(CMD_LOAD, SLOT_W'($urandom_range(0, 63)), $urandom, $urandom, v, v, v);
    end else if (kind <= 8 && n > 0) begin
      k = $urandom_range(0, ((n > MAX_TRACKS) ? MAX_TRACKS : n) - 1);
      send(CMD_MEASURE, SLOT_W'($urandom),
           32'(sb.pred_x[k] + $urandom_range(0, 1 << 19) - (1 << 18)),
           32'(sb.pred_y[k] + $urandom_range(0, 1 << 19) - (1 << 18)),
           $urandom, $urandom, $urandom);
    end else
      send(CMD_MEASURE, SLOT_W'($urandom), $urandom, $urandom, $urandom, $urandom,
           $urandom);
  endtask

  initial begin
    int          n, sel, items;
    logic [31:0] r;
    rst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_index = REG_MAX_RADIUS;
    cfg_data = '0; in_command = CMD_LOAD; in_slot = '0;
    in_pos_x = '0; in_pos_y = '0; in_cov_xx = '0; in_cov_xy = '0; in_cov_yy = '0;
    gaps_on = 1;
    rand_items = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. With a track count of zero a measurement gives nothing.
    send(CMD_MEASURE, 0, 0, 0, 0, 0, 0);
    send(CMD_LOAD, 0, 0, 0, 65536, 0, 65536);
    send(CMD_LOAD, 1, 65536, 0, 65536, 65536, 65536);
    send(CMD_LOAD, 2, 0, 65536, 65536, 131072, 65536);
    send(CMD_LOAD, 3, 0, 0, 1, 0, 1);
    send(CMD_LOAD, 4, -65536, 0, -65536, 0, 65536);
    send(CMD_LOAD, 63, 32'sh7FFF_FFFF, 32'sh8000_0000,
         32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send(CMD_LOAD, 5, 32'sh8000_0000, 32'sh7FFF_FFFF,
         32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    set_regs(32'd327680, 6);
    send(CMD_MEASURE, 0, 0, 0, 0, 0, 0);
    send(CMD_MEASURE, 63, 65536, -65536, 32'sh7FFF_FFFF, 0, 0);
    send(CMD_MEASURE, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0);
    set_regs(32'hFFFF_FFFF, 6);
    send(CMD_MEASURE, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0);
    send(CMD_MEASURE, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0);
    send(CMD_MEASURE, 0, 3000, -5000, 0, 0, 0);
    set_regs(32'd0, 6);
    send(CMD_MEASURE, 0, 0, 0, 0, 0, 0);
    send(CMD_MEASURE, 0, 1, 0, 0, 0, 0);
    // A count above the table size scores every slot.
    fill_slots(MAX_TRACKS);
    set_regs(32'hFFFF_FFFF, 7'd127);
    send(CMD_MEASURE, 0, 0, 0, 0, 0, 0);
    send(CMD_MEASURE, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0);

    while (rand_items < 430) begin
      sel = $urandom_range(0, 9);
      n = (sel == 0) ? 0 : (sel == 1) ? 127 : (sel == 2) ? 64 :
          (sel == 3) ? $urandom_range(9, 63) : $urandom_range(1, 8);
      sel = $urandom_range(0, 5);
      r = (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFFFF_FFFF : (sel == 2) ? 32'd327680 :
          (sel == 3) ? $urandom : $urandom_range(1 << 16, 1 << 23);
      set_regs(r, n);
      fill_slots(n);
      items = $urandom_range(10, 30);
      for (int i = 0; i < items; i++) begin
        gaps_on = (rand_items < 390);
        random_item(n);
      end
    end
    drain();
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
